// ----- hw/rtl/itse_pkg.sv -----
// Shared types, constants and calendar helpers for the timestamp-to-epoch block.
package itse_pkg;

   localparam int unsigned NumDigits = 14;
   localparam int unsigned StrLen    = 16;

   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;
   localparam logic [7:0] CharT    = 8'h54;
   localparam logic [7:0] CharZ    = 8'h5A;

   localparam logic [4:0] PosTee   = 5'd8;
   localparam logic [4:0] PosLast  = 5'd15;
   localparam logic [4:0] PosSat   = 5'd16;

   localparam logic [13:0] YearBelow = 14'd1969;
   localparam logic [13:0] YearAbove = 14'd2039;
   localparam logic [13:0] YearBase  = 14'd1970;
   localparam logic [6:0]  MonthAbove = 7'd13;
   localparam logic [6:0]  DayAbove   = 7'd32;
   localparam logic [6:0]  HourMax    = 7'd24;
   localparam logic [6:0]  MinSecMax  = 7'd59;

   localparam logic [31:0] SecPerDay  = 32'd86400;
   localparam logic [16:0] SecPerHour = 17'd3600;
   localparam logic [16:0] SecPerMin  = 17'd60;
   localparam logic [14:0] DaysPerYear = 15'd365;

   typedef logic [NumDigits-1:0][3:0] digits_type;

   typedef struct packed {
      logic       ok;
      logic [6:0] year_off;
      logic [3:0] month_idx;
      logic [4:0] day_off;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } fields_type;

   typedef struct packed {
      logic        ok;
      logic [14:0] days;
      logic [16:0] hms;
   } days_type;

   // Days before the first of each month in a common year.
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] res;
      case (idx)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd59;
         4'd3:    res = 9'd90;
         4'd4:    res = 9'd120;
         4'd5:    res = 9'd151;
         4'd6:    res = 9'd181;
         4'd7:    res = 9'd212;
         4'd8:    res = 9'd243;
         4'd9:    res = 9'd273;
         4'd10:   res = 9'd304;
         4'd11:   res = 9'd334;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

// ----- hw/rtl/itse_collect.sv -----
// Character collector: checks each character, gathers the digits, hands on a finished string.
module itse_collect (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_code,
   input  logic                   req_is_last,
   output logic                   str_valid,
   input  logic                   str_ready,
   output itse_pkg::digits_type   str_digits,
   output logic                   str_pre_ok
);

   logic [4:0]           pos_ff, pos_in;
   itse_pkg::digits_type digits_ff, digits_in, digits_upd;
   logic                 err_ff, err_in;
   logic                 sv_ff, sv_in;
   itse_pkg::digits_type sd_ff, sd_in;
   logic                 sok_ff, sok_in;

   logic       accept;
   logic       is_digit;
   logic       digit_pos;
   logic       wrong;
   logic [3:0] didx;

   assign req_ready = !sv_ff || str_ready;
   assign accept    = req_valid && req_ready;

   assign is_digit  = (req_char_code >= itse_pkg::CharZero) &&
                      (req_char_code <= itse_pkg::CharNine);
   assign digit_pos = (pos_ff inside {[5'd0:5'd7], [5'd9:5'd14]});
   assign didx      = (pos_ff <= 5'd7) ? pos_ff[3:0] : 4'(pos_ff - 5'd1);

   always_comb begin
      if (digit_pos) begin
         wrong = !is_digit;
      end else if (pos_ff == itse_pkg::PosTee) begin
         wrong = (req_char_code != itse_pkg::CharT);
      end else if (pos_ff == itse_pkg::PosLast) begin
         wrong = (req_char_code != itse_pkg::CharZ);
      end else begin
         wrong = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < itse_pkg::NumDigits; i++) begin
         digits_upd[i] = digits_ff[i];
         if (digit_pos && is_digit && (didx == 4'(i))) begin
            digits_upd[i] = req_char_code[3:0];
         end
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      digits_in = digits_ff;
      err_in    = err_ff;
      sv_in     = sv_ff && !str_ready;
      sd_in     = sd_ff;
      sok_in    = sok_ff;
      if (accept) begin
         if (req_is_last) begin
            // string done: hand on and start afresh
            pos_in    = '0;
            digits_in = '0;
            err_in    = 1'b0;
            sv_in     = 1'b1;
            sd_in     = digits_ff;
            sok_in    = !(err_ff || wrong) && (pos_ff == itse_pkg::PosLast);
         end else begin
            if (pos_ff < itse_pkg::PosSat) begin
               pos_in = pos_ff + 5'd1;
            end
            digits_in = digits_upd;
            err_in    = err_ff || wrong;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         digits_ff <= '0;
         err_ff    <= 1'b0;
         sv_ff     <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         digits_ff <= digits_in;
         err_ff    <= err_in;
         sv_ff     <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      sd_ff  <= sd_in;
      sok_ff <= sok_in;
   end

   assign str_valid  = sv_ff;
   assign str_digits = sd_ff;
   assign str_pre_ok = sok_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= itse_pkg::PosSat)
      else $error("character position past saturation");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_is_last |=> pos_ff == 5'd0 && !err_ff && str_valid)
      else $error("string end did not restart collection");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      str_valid && !str_ready |=> str_valid && $stable(str_pre_ok))
      else $error("pending string lost");

endmodule

// ----- hw/rtl/itse_fields.sv -----
// Field decoder: turns digits into binary fields and range-checks them.
module itse_fields (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  itse_pkg::digits_type   in_digits,
   input  logic                   in_pre_ok,
   output logic                   out_valid,
   input  logic                   out_ready,
   output itse_pkg::fields_type   out_fields
);

   logic                 v_ff, v_in;
   itse_pkg::fields_type f_ff, f_in;
   logic                 load;

   logic [13:0] year;
   logic [6:0]  month, day, hour, minute, second;
   logic        ok;

   assign in_ready = !v_ff || out_ready;
   assign load     = in_valid && in_ready;

   assign year   = 14'(in_digits[0]) * 14'd1000 + 14'(in_digits[1]) * 14'd100
                 + 14'(in_digits[2]) * 14'd10 + 14'(in_digits[3]);
   assign month  = 7'(in_digits[4]) * 7'd10 + 7'(in_digits[5]);
   assign day    = 7'(in_digits[6]) * 7'd10 + 7'(in_digits[7]);
   assign hour   = 7'(in_digits[8]) * 7'd10 + 7'(in_digits[9]);
   assign minute = 7'(in_digits[10]) * 7'd10 + 7'(in_digits[11]);
   assign second = 7'(in_digits[12]) * 7'd10 + 7'(in_digits[13]);

   assign ok = in_pre_ok
            && (year > itse_pkg::YearBelow) && (year < itse_pkg::YearAbove)
            && (month != 7'd0) && (month < itse_pkg::MonthAbove)
            && (day != 7'd0) && (day < itse_pkg::DayAbove)
            && (hour <= itse_pkg::HourMax)
            && (minute <= itse_pkg::MinSecMax) && (second <= itse_pkg::MinSecMax);

   always_comb begin
      v_in = load ? 1'b1 : (v_ff && !out_ready);
      f_in = f_ff;
      if (load) begin
         f_in.ok        = ok;
         f_in.year_off  = 7'(year - itse_pkg::YearBase);
         f_in.month_idx = 4'(month - 7'd1);
         f_in.day_off   = 5'(day - 7'd1);
         f_in.hour      = hour[4:0];
         f_in.minute    = minute[5:0];
         f_in.second    = second[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff <= f_in;
   end

   assign out_valid  = v_ff;
   assign out_fields = f_ff;

endmodule

// ----- hw/rtl/itse_days.sv -----
// Day counter: days since 1970 and seconds within the day.
module itse_days (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  itse_pkg::fields_type   in_fields,
   output logic                   out_valid,
   input  logic                   out_ready,
   output itse_pkg::days_type     out_days
);

   logic               v_ff, v_in;
   itse_pkg::days_type d_ff, d_in;
   logic               load;

   logic [7:0]  yp1;
   logic [14:0] leaps;
   logic        leap_adj;
   logic [14:0] days;
   logic [16:0] hms;

   assign in_ready = !v_ff || out_ready;
   assign load     = in_valid && in_ready;

   // leap years from 1970 up to the year before; 2000 is the only century and it is leap
   assign yp1      = 8'(in_fields.year_off) + 8'd1;
   assign leaps    = 15'(yp1[7:2]);
   assign leap_adj = (in_fields.year_off[1:0] == 2'd2) && (in_fields.month_idx >= 4'd2);

   assign days = 15'(in_fields.year_off) * itse_pkg::DaysPerYear + leaps
               + 15'(itse_pkg::month_start(in_fields.month_idx))
               + 15'(leap_adj) + 15'(in_fields.day_off);
   assign hms  = 17'(in_fields.hour) * itse_pkg::SecPerHour
               + 17'(in_fields.minute) * itse_pkg::SecPerMin + 17'(in_fields.second);

   always_comb begin
      v_in = load ? 1'b1 : (v_ff && !out_ready);
      d_in = d_ff;
      if (load) begin
         d_in.ok   = in_fields.ok;
         d_in.days = days;
         d_in.hms  = hms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_days  = d_ff;

endmodule

// ----- hw/rtl/iso8601_timestamp_to_epoch_top.sv -----
// Top level: basic ISO 8601 UTC timestamp string to Unix seconds.
// rsp_valid rises once the finished string has passed through the string, fields, days and result registers.
// Throughput: one character request per cycle; the four stages (string, fields, days,
// result) each hold one string, so requests stall only once all four are full.
// Reset (synchronous, active high) clears the character position, error flag and all
// stage valid flags; a new string starts with the next request.
module iso8601_timestamp_to_epoch_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [31:0] rsp_epoch_seconds
);

   logic                 str_valid, str_ready, str_pre_ok;
   itse_pkg::digits_type str_digits;
   logic                 fld_valid, fld_ready;
   itse_pkg::fields_type fld;
   logic                 day_valid, day_ready;
   itse_pkg::days_type   dd;

   logic        rv_ff, rv_in;
   logic        rok_ff, rok_in;
   logic [31:0] rsec_ff, rsec_in;
   logic        load;

   itse_collect u_collect (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .str_valid     (str_valid),
      .str_ready     (str_ready),
      .str_digits    (str_digits),
      .str_pre_ok    (str_pre_ok)
   );

   itse_fields u_fields (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (str_valid),
      .in_ready   (str_ready),
      .in_digits  (str_digits),
      .in_pre_ok  (str_pre_ok),
      .out_valid  (fld_valid),
      .out_ready  (fld_ready),
      .out_fields (fld)
   );

   itse_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fld_valid),
      .in_ready  (fld_ready),
      .in_fields (fld),
      .out_valid (day_valid),
      .out_ready (day_ready),
      .out_days  (dd)
   );

   assign day_ready = !rv_ff || rsp_ready;
   assign load      = day_valid && day_ready;

   always_comb begin
      rv_in   = load ? 1'b1 : (rv_ff && !rsp_ready);
      rok_in  = rok_ff;
      rsec_in = rsec_ff;
      if (load) begin
         rok_in  = dd.ok;
         rsec_in = dd.ok ? (32'(dd.days) * itse_pkg::SecPerDay + 32'(dd.hms)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rok_ff  <= rok_in;
      rsec_ff <= rsec_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_ok            = rok_ff;
   assign rsp_epoch_seconds = rsec_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_epoch_seconds == 32'd0)
      else $error("failed conversion gave non-zero seconds");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_epoch_seconds <= 32'd2177456399)
      else $error("seconds beyond 2038 range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_epoch_seconds))
      else $error("pending result changed");

endmodule
